FILE: hw/rtl/nnis_pkg.sv
// Shared constants and types for the nearest-neighbor image scaler.
package nnis_pkg;

    // Frame store geometry.
    localparam int MAX_SRC_WIDTH  = 256;
    localparam int MAX_SRC_HEIGHT = 256;
    localparam int SX_W   = $clog2(MAX_SRC_WIDTH);
    localparam int SY_W   = $clog2(MAX_SRC_HEIGHT);
    localparam int ADDR_W = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT);
    localparam int DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;

    // Field widths.
    localparam int POS_W  = 12;
    localparam int SRC_W  = 9;
    localparam int DST_W  = 13;
    localparam int PIX_W  = 32;
    localparam int IDX_W  = 2;
    localparam int CFG_W  = 13;
    localparam int IN_DW  = 56;
    localparam int OUT_DW = 32;

    // Divider: two quotient bits per stage.
    localparam int QW_MAX     = (SX_W > SY_W) ? SX_W : SY_W;
    localparam int DIV_STAGES = (QW_MAX + 1) / 2;
    localparam int DIV_QW     = 2 * DIV_STAGES;
    localparam int NUM_W      = POS_W + SRC_W;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_DST_WIDTH  = 2'd2,
        REG_DST_HEIGHT = 2'd3
    } t_reg_idx;

    // Request kinds carried in tuser.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef logic [NUM_W-1:0] t_num;

    // Side information that travels beside the divider.
    typedef struct packed {
        logic             valid;
        logic             rd;
        logic             err;
        logic             wen;
        logic [SX_W-1:0]  wx;
        logic [SY_W-1:0]  wy;
        logic [PIX_W-1:0] pix;
    } t_sb;

endpackage

FILE: hw/rtl/nnis_divider.sv
// Pipelined restoring divider, two quotient bits per stage.
module nnis_divider (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  nnis_pkg::t_num            i_num,
    input  logic [nnis_pkg::DST_W-1:0] i_den,
    output logic [nnis_pkg::DIV_QW-1:0] o_quo
);
    import nnis_pkg::*;

    t_num              r_rem [DIV_STAGES];
    logic [DIV_QW-1:0] r_quo [DIV_STAGES];
    t_num              n_rem [DIV_STAGES];
    logic [DIV_QW-1:0] n_quo [DIV_STAGES];

    // Each stage tries two shifted divisors, high bit first.
    always_comb begin
        t_num rem;
        t_num dsh;
        logic [DIV_QW-1:0] quo;
        for (int s = 0; s < DIV_STAGES; s++) begin
            rem = (s == 0) ? i_num : r_rem[(s == 0) ? 0 : s - 1];
            quo = (s == 0) ? '0 : r_quo[(s == 0) ? 0 : s - 1];
            for (int b = 0; b < 2; b++) begin
                dsh = t_num'(i_den) << (DIV_QW - 1 - 2 * s - b);
                if (rem >= dsh) begin
                    rem = rem - dsh;
                    quo[DIV_QW - 1 - 2 * s - b] = 1'b1;
                end
            end
            n_rem[s] = rem;
            n_quo[s] = quo;
        end
    end

    // Stage registers advance together with the block pipeline.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_rem[s] <= n_rem[s];
                r_quo[s] <= n_quo[s];
            end
        end
    end

    assign o_quo = r_quo[DIV_STAGES-1];

endmodule

FILE: hw/rtl/nearest_neighbor_image_scaler_unit.sv
// Top level of the nearest-neighbor image scaler with its frame store.
//
// Channel   Direction  Beat contents
// s_axis    in         tuser: req_type; tdata: pos_x, pos_y, alpha, red, green, blue
// m_axis    out        tuser: coord_error; tdata: alpha, red, green, blue
// cfg       in         i_cfg_index: register, i_cfg_data: value; always ready
//
// One beat enters per cycle unless m_axis stalls; a read result passes through the input
// register, the multiply stage, the four divider stages and the store read register.
// Writes travel the same pipeline, so reads and writes keep their order.
// A stall on m_axis freezes every stage; s_axis tready drops with it.
// Reset (i_rst_n low, synchronous) clears valid bits and sizes to 256.
module nearest_neighbor_image_scaler_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [nnis_pkg::IN_DW-1:0]    s_axis_tdata,   // pos_x, pos_y, a, r, g, b
    input  logic                          s_axis_tuser,   // req_type
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [nnis_pkg::OUT_DW-1:0]   m_axis_tdata,   // alpha, red, green, blue
    output logic                          m_axis_tuser,   // coord_error
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [nnis_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [nnis_pkg::CFG_W-1:0]    i_cfg_data
);
    import nnis_pkg::*;

    logic [SRC_W-1:0] r_src_width, r_src_height;
    logic [DST_W-1:0] r_dst_width, r_dst_height;
    logic             en;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= SRC_W'(256);
            r_src_height <= SRC_W'(256);
            r_dst_width  <= DST_W'(256);
            r_dst_height <= DST_W'(256);
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_SRC_WIDTH:  r_src_width  <= i_cfg_data[SRC_W-1:0];
                REG_SRC_HEIGHT: r_src_height <= i_cfg_data[SRC_W-1:0];
                REG_DST_WIDTH:  r_dst_width  <= i_cfg_data;
                REG_DST_HEIGHT: r_dst_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Global pipeline advance.
    logic r_o_valid;
    assign en            = !r_o_valid || m_axis_tready;
    assign s_axis_tready = en;

    // Input stage.
    logic             r0_valid, r0_req;
    logic [POS_W-1:0] r0_x, r0_y;
    logic [PIX_W-1:0] r0_pix;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (en) begin
            r0_valid <= s_axis_tvalid;
        end
        if (en) begin
            r0_req <= s_axis_tuser;
            r0_x   <= s_axis_tdata[11:0];
            r0_y   <= s_axis_tdata[23:12];
            r0_pix <= s_axis_tdata[55:24];
        end
    end

    // Multiply stage: clamp source size, form numerators and flags.
    logic [SRC_W-1:0] sw, sh;
    t_num             r1_nx, r1_ny;
    t_sb              r1_sb, n1_sb;
    assign sw = (r_src_width  > SRC_W'(MAX_SRC_WIDTH))  ? SRC_W'(MAX_SRC_WIDTH)  : r_src_width;
    assign sh = (r_src_height > SRC_W'(MAX_SRC_HEIGHT)) ? SRC_W'(MAX_SRC_HEIGHT) : r_src_height;

    always_comb begin
        n1_sb.valid = r0_valid;
        n1_sb.rd    = (r0_req == REQ_READ);
        n1_sb.err   = (r0_req == REQ_READ) &&
                      ((DST_W'(r0_x) >= r_dst_width) || (DST_W'(r0_y) >= r_dst_height));
        n1_sb.wen   = r0_valid && (r0_req == REQ_WRITE) &&
                      (DST_W'(r0_x) < DST_W'(sw)) && (DST_W'(r0_y) < DST_W'(sh));
        n1_sb.wx    = r0_x[SX_W-1:0];
        n1_sb.wy    = r0_y[SY_W-1:0];
        n1_sb.pix   = r0_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_sb.valid <= 1'b0;
        end else if (en) begin
            r1_sb.valid <= n1_sb.valid;
        end
        if (en) begin
            r1_nx <= NUM_W'(r0_x) * NUM_W'(sw);
            r1_ny <= NUM_W'(r0_y) * NUM_W'(sh);
            r1_sb.rd  <= n1_sb.rd;
            r1_sb.err <= n1_sb.err;
            r1_sb.wen <= n1_sb.wen;
            r1_sb.wx  <= n1_sb.wx;
            r1_sb.wy  <= n1_sb.wy;
            r1_sb.pix <= n1_sb.pix;
        end
    end

    // Divider stages for column and row.
    logic [DIV_QW-1:0] qx, qy;
    nnis_divider u_div_x (
        .i_clk (i_clk), .i_en (en), .i_num (r1_nx), .i_den (r_dst_width), .o_quo (qx)
    );
    nnis_divider u_div_y (
        .i_clk (i_clk), .i_en (en), .i_num (r1_ny), .i_den (r_dst_height), .o_quo (qy)
    );

    // Side information delayed to match the divider.
    t_sb r_sb [DIV_STAGES];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_STAGES; s++) r_sb[s].valid <= 1'b0;
        end else if (en) begin
            r_sb[0].valid <= r1_sb.valid;
            for (int s = 1; s < DIV_STAGES; s++) r_sb[s].valid <= r_sb[s-1].valid;
        end
        if (en) begin
            r_sb[0].rd  <= r1_sb.rd;
            r_sb[0].err <= r1_sb.err;
            r_sb[0].wen <= r1_sb.wen;
            r_sb[0].wx  <= r1_sb.wx;
            r_sb[0].wy  <= r1_sb.wy;
            r_sb[0].pix <= r1_sb.pix;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_sb[s].rd  <= r_sb[s-1].rd;
                r_sb[s].err <= r_sb[s-1].err;
                r_sb[s].wen <= r_sb[s-1].wen;
                r_sb[s].wx  <= r_sb[s-1].wx;
                r_sb[s].wy  <= r_sb[s-1].wy;
                r_sb[s].pix <= r_sb[s-1].pix;
            end
        end
    end

    // Frame store access: write or read in order.
    t_sb               sb_m;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [PIX_W-1:0]  mem [DEPTH];
    logic [PIX_W-1:0]  r_rd;
    logic              r_o_err;
    assign sb_m    = r_sb[DIV_STAGES-1];
    assign rd_addr = ADDR_W'(qy[SY_W-1:0]) * ADDR_W'(MAX_SRC_WIDTH) + ADDR_W'(qx[SX_W-1:0]);
    assign wr_addr = ADDR_W'(sb_m.wy) * ADDR_W'(MAX_SRC_WIDTH) + ADDR_W'(sb_m.wx);

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (sb_m.wen) begin
                mem[wr_addr] <= sb_m.pix;
            end
            r_rd <= mem[rd_addr];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= sb_m.valid && sb_m.rd;
        end
        if (en) begin
            r_o_err <= sb_m.err;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tuser  = r_o_err;
    assign m_axis_tdata  = r_o_err ? '0 : r_rd;

endmodule

FILE: sim/nnis_pixel_checker.sv
// Checker for the nearest-neighbor image scaler: predicts every read result and compares it.
`timescale 1ns / 100ps

module nnis_pixel_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [nnis_pkg::IN_DW-1:0]    s_axis_tdata,   // pos_x, pos_y, alpha, red, green, blue
    input  logic                          s_axis_tuser,   // req_type
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [nnis_pkg::OUT_DW-1:0]   m_axis_tdata,   // alpha, red, green, blue
    input  logic                          m_axis_tuser,   // coord_error
    input  logic                          i_cfg_valid,
    input  logic                          o_cfg_ready,
    input  logic [nnis_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [nnis_pkg::CFG_W-1:0]    i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_result_count
);
    import nnis_pkg::*;

    // One scaled pixel as it leaves the block.
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       coord_err;
    } t_scaled_pixel;

    // Private copy of the frame store and of the size registers.
    logic [PIX_W-1:0] source_pixels [DEPTH];
    logic [SRC_W-1:0] src_w, src_h;
    logic [DST_W-1:0] dst_w, dst_h;
    t_scaled_pixel    awaited_pixels [$];
    int               fails = 0;
    int               results = 0;

    // Map a destination coordinate back to its nearest stored source pixel.
    function automatic t_scaled_pixel scale_lookup(logic [POS_W-1:0] x, logic [POS_W-1:0] y);
        t_scaled_pixel res;
        int unsigned   sw, sh, sx, sy;
        logic [31:0]   word;
        res = '0;
        if (x >= dst_w || y >= dst_h) begin
            res.coord_err = 1'b1;
            return res;
        end
        sw = (src_w > MAX_SRC_WIDTH) ? MAX_SRC_WIDTH : src_w;
        sh = (src_h > MAX_SRC_HEIGHT) ? MAX_SRC_HEIGHT : src_h;
        sx = (int'(x) * sw) / dst_w;
        sy = (int'(y) * sh) / dst_h;
        word = source_pixels[sy * MAX_SRC_WIDTH + sx];
        res.alpha = word[31:24];
        res.red   = word[23:16];
        res.green = word[15:8];
        res.blue  = word[7:0];
        return res;
    endfunction

    // Watch all three channels at each edge.
    always @(posedge i_clk) begin
        logic [POS_W-1:0] x, y;
        int unsigned      sw, sh;
        t_scaled_pixel    got, want;
        if (!i_rst_n) begin
            src_w = 9'd256;
            src_h = 9'd256;
            dst_w = 13'd256;
            dst_h = 13'd256;
            awaited_pixels.delete();
        end else begin
            // Result beats are compared with the oldest prediction.
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                       m_axis_tdata[31:24], m_axis_tuser};
                results++;
                if (awaited_pixels.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: result beat with nothing expected: %h", $realtime, got);
                end else begin
                    want = awaited_pixels.pop_front();
                    if (got.alpha !== want.alpha || got.red !== want.red ||
                        got.green !== want.green || got.blue !== want.blue ||
                        got.coord_err !== want.coord_err) begin
                        fails++;
                        if (fails <= 10)
                            $display("%0t: expected %h %h %h %h %b, got %h %h %h %h %b",
                                     $realtime, want.alpha, want.red, want.green, want.blue,
                                     want.coord_err, got.alpha, got.red, got.green, got.blue,
                                     got.coord_err);
                    end
                end
            end
            // Register writes.
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_SRC_WIDTH:  src_w = i_cfg_data[SRC_W-1:0];
                    REG_SRC_HEIGHT: src_h = i_cfg_data[SRC_W-1:0];
                    REG_DST_WIDTH:  dst_w = i_cfg_data;
                    REG_DST_HEIGHT: dst_h = i_cfg_data;
                    default: ;
                endcase
            end
            // Request beats: writes update the store, reads queue a prediction.
            if (s_axis_tvalid && s_axis_tready) begin
                x = s_axis_tdata[11:0];
                y = s_axis_tdata[23:12];
                if (s_axis_tuser == REQ_WRITE) begin
                    sw = (src_w > MAX_SRC_WIDTH) ? MAX_SRC_WIDTH : src_w;
                    sh = (src_h > MAX_SRC_HEIGHT) ? MAX_SRC_HEIGHT : src_h;
                    if (x < sw && y < sh)
                        source_pixels[int'(y) * MAX_SRC_WIDTH + x] =
                            {s_axis_tdata[31:24], s_axis_tdata[39:32],
                             s_axis_tdata[47:40], s_axis_tdata[55:48]};
                end else begin
                    awaited_pixels = {awaited_pixels, scale_lookup(x, y)};
                end
            end
        end
        o_fail_count   <= fails;
        o_pending      <= awaited_pixels.size();
        o_result_count <= results;
    end

endmodule

FILE: sim/tb_nearest_neighbor_image_scaler_unit.sv
// Testbench top for the nearest-neighbor image scaler: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_nearest_neighbor_image_scaler_unit;
    import nnis_pkg::*;

    localparam int IDLE_LIMIT  = 5000;
    localparam int RANDOM_GOAL = 1350;

    logic              i_clk;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_DW-1:0]  s_axis_tdata  = '0;   // pos_x, pos_y, alpha, red, green, blue
    logic              s_axis_tuser  = 1'b0; // req_type
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_DW-1:0] m_axis_tdata;         // alpha, red, green, blue
    logic              m_axis_tuser;         // coord_error
    logic              i_cfg_valid   = 1'b0;
    logic              o_cfg_ready;
    logic [IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_W-1:0]  i_cfg_data    = '0;
    int                fail_count, pending, result_count;

    // Stimulus bookkeeping: current sizes and which store entries hold data.
    int unsigned cur_sw = 256, cur_sh = 256, cur_dw = 256, cur_dh = 256;
    bit          written [DEPTH];
    int          burst_left = 0;
    int          random_items = 0;
    int          reads_sent = 0, writes_sent = 0, outside_reads = 0, phases = 0;
    int          idle_cycles = 0;

    nearest_neighbor_image_scaler_unit i_dut (.*);

    nnis_pixel_checker i_checker (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    // Clock, 4 ns period.
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Receiver stalls, switching at random between four patterns.
    always @(posedge i_clk) begin
        int unsigned mode;
        int unsigned cyc;
        cyc++;
        if (cyc % 300 == 0)
            mode = $urandom_range(0, 3);
        case (mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (cyc[3:2] != 2'b11);
        endcase
    end

    // Watchdog on cycles in which no beat moves on any channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int unsigned eff_sw();
        return (cur_sw > MAX_SRC_WIDTH) ? MAX_SRC_WIDTH : cur_sw;
    endfunction

    function automatic int unsigned eff_sh();
        return (cur_sh > MAX_SRC_HEIGHT) ? MAX_SRC_HEIGHT : cur_sh;
    endfunction

    // Present one request beat, idling in bursts, and wait for its handshake.
    task automatic send_beat(logic req, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                             logic [31:0] argb);
        int gap;
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {argb[7:0], argb[15:8], argb[23:16], argb[31:24], y, x};
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
        random_items++;
        if (req == REQ_WRITE) begin
            writes_sent++;
            if (x < eff_sw() && y < eff_sh())
                written[int'(y) * MAX_SRC_WIDTH + x] = 1'b1;
        end else begin
            reads_sent++;
        end
    endtask

    // Read a destination pixel, first storing its source pixel if it was never written.
    task automatic scaled_read(logic [POS_W-1:0] x, logic [POS_W-1:0] y);
        int unsigned sx, sy;
        if (x < cur_dw && y < cur_dh) begin
            sx = (int'(x) * eff_sw()) / cur_dw;
            sy = (int'(y) * eff_sh()) / cur_dh;
            if (!written[sy * MAX_SRC_WIDTH + sx]) begin
                if (sx < eff_sw() && sy < eff_sh()) begin
                    send_beat(REQ_WRITE, POS_W'(sx), POS_W'(sy), $urandom);
                end else begin
                    // The entry cannot be written under this size, so a write goes instead.
                    send_beat(REQ_WRITE, x, y, $urandom);
                    return;
                end
            end
        end else begin
            outside_reads++;
        end
        send_beat(REQ_READ, x, y, $urandom);
    endtask

    // Stop sending and wait until every result is back and the pipeline is empty.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, int unsigned val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[CFG_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_SRC_WIDTH:  cur_sw = val & 32'h1FF;
            REG_SRC_HEIGHT: cur_sh = val & 32'h1FF;
            REG_DST_WIDTH:  cur_dw = val & 32'h1FFF;
            REG_DST_HEIGHT: cur_dh = val & 32'h1FFF;
            default: ;
        endcase
    endtask

    task automatic set_sizes(int unsigned sw, int unsigned sh, int unsigned dw, int unsigned dh);
        write_reg(REG_SRC_WIDTH, sw);
        write_reg(REG_SRC_HEIGHT, sh);
        write_reg(REG_DST_WIDTH, dw);
        write_reg(REG_DST_HEIGHT, dh);
    endtask

    // Coordinate biased toward the edge of a size, with some full-range noise.
    function automatic logic [POS_W-1:0] pick_coord(int unsigned lim);
        int unsigned top;
        top = (lim > 4096) ? 4096 : lim;
        case ($urandom_range(0, 9))
            0: return POS_W'($urandom_range(0, 4095));
            1: return POS_W'((top > 4095) ? 4095 : top);
            2: return POS_W'((top == 0) ? 0 : top - 1);
            default: return POS_W'((top == 0) ? 0 : $urandom_range(0, top - 1));
        endcase
    endfunction

    // Pick one of the interesting source sizes.
    function automatic int unsigned pick_src();
        case ($urandom_range(0, 9))
            0: return 1;
            1: return 256;
            2: return $urandom_range(257, 511);
            3: return ($urandom_range(0, 3) == 0) ? 0 : 2;
            default: return $urandom_range(1, 16);
        endcase
    endfunction

    function automatic int unsigned pick_dst();
        case ($urandom_range(0, 9))
            0: return 1;
            1: return 4096;
            2: return $urandom_range(4097, 8191);
            3: return ($urandom_range(0, 3) == 0) ? 0 : 256;
            default: return $urandom_range(1, 64);
        endcase
    endfunction

    initial begin
        int unsigned n;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: corners of the store, ignored writes, outside reads.
        send_beat(REQ_WRITE, 0, 0, 32'hFFFF_FFFF);
        send_beat(REQ_WRITE, 255, 255, 32'h0000_0000);
        send_beat(REQ_WRITE, 255, 0, 32'hA5A5_5A5A);
        send_beat(REQ_WRITE, 0, 255, 32'h5A5A_A5A5);
        send_beat(REQ_WRITE, 256, 0, 32'h1234_5678);
        send_beat(REQ_WRITE, 4095, 4095, 32'hFFFF_FFFF);
        scaled_read(0, 0);
        scaled_read(255, 255);
        scaled_read(255, 0);
        scaled_read(0, 255);
        scaled_read(256, 0);
        scaled_read(0, 256);
        scaled_read(4095, 4095);
        // Zero destination size: every read lies outside.
        set_sizes(256, 256, 0, 0);
        scaled_read(0, 0);
        // Oversized destination and source: reads never fall outside.
        set_sizes(511, 511, 8191, 8191);
        scaled_read(4095, 4095);
        scaled_read(0, 4095);
        // Zero source size: writes ignored, reads map to column and row zero.
        set_sizes(0, 0, 16, 16);
        send_beat(REQ_WRITE, 0, 0, 32'h0F0F_0F0F);
        scaled_read(0, 0);
        scaled_read(15, 15);
        scaled_read(16, 3);
        random_items = 0;

        // Random phases, each with its own sizes.
        while (random_items < RANDOM_GOAL) begin
            case (phases)
                0:       set_sizes(1, 1, 4096, 4096);
                1:       set_sizes(256, 256, 1, 1);
                default: set_sizes(pick_src(), pick_src(), pick_dst(), pick_dst());
            endcase
            phases++;
            // Small sources are filled in scan order first.
            if (eff_sw() * eff_sh() <= 256) begin
                for (int yy = 0; yy < eff_sh(); yy++)
                    for (int xx = 0; xx < eff_sw(); xx++)
                        send_beat(REQ_WRITE, POS_W'(xx), POS_W'(yy), $urandom);
            end
            n = $urandom_range(40, 120);
            repeat (n) begin
                if ($urandom_range(0, 4) == 0)
                    send_beat(REQ_WRITE, pick_coord(eff_sw()), pick_coord(eff_sh()), $urandom);
                else
                    scaled_read(pick_coord(cur_dw), pick_coord(cur_dh));
            end
        end

        drain();
        $display("Covered %0d size settings: %0d pixel writes, %0d scaled reads (%0d off-image).",
                 phases + 3, writes_sent, reads_sent, outside_reads);
        $display("Checked %0d result beats under random receiver stalls.", result_count);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
